// ===== rtl/core/sha_pkg.sv =====
// Package for the SHA-256 byte stream hasher: constants, types and helper functions.
package sha_pkg;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned WordCount  = 16;
  localparam int unsigned LenStart   = 56;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [RoundCount] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Source of the byte written into the block buffer
  typedef enum logic [1:0] {
    BSEL_DATA = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } bsel_t;

  typedef struct packed {
    logic  wr_byte;
    bsel_t byte_sel;
    logic  count_bits;
    logic  rnd_init;
    logic  rnd_step;
    logic  chain_add;
    logic  out_step;
    logic  init_msg;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       rnd_last;
    logic       word_last;
  } dp_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha_if.sv =====
// Valid/ready channel interfaces for message bytes and digest words.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/sha_dp.sv =====
// Datapath: block word window, counters, chaining words and the round unit.
module sha_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::dp_cmd_t  cmd,
  output sha_pkg::dp_sts_t  sts,
  input  logic [7:0]        data_byte,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index
);

  logic [31:0] w_r     [sha_pkg::WordCount];
  logic [31:0] chain_r [8];
  logic [31:0] v_r     [8];
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [5:0]  rnd_r;
  logic [2:0]  widx_r;

  logic [7:0]  byte_val;
  logic [4:0]  lane_lsb;
  logic [31:0] w_new, s0, s1, big0, big1, ch, maj, t1, t2;

  // Byte to store
  always_comb begin
    case (cmd.byte_sel)
      sha_pkg::BSEL_DATA: byte_val = data_byte;
      sha_pkg::BSEL_PAD:  byte_val = sha_pkg::PadByte;
      sha_pkg::BSEL_LEN:  byte_val = bits_r[{~fill_r[2:0], 3'b000} +: 8];
      default:            byte_val = 8'h00;
    endcase
  end

  assign lane_lsb = {~fill_r[1:0], 3'b000};

  // Schedule and round functions
  always_comb begin
    s0   = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    big1 = sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11) ^ sha_pkg::rotr(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + sha_pkg::RoundK[rnd_r] + w_r[0];
    big0 = sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13) ^ sha_pkg::rotr(v_r[0], 22);
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + maj;
  end

  // Word window: byte writes, shifted once per round
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      w_r[fill_r[5:2]][lane_lsb +: 8] <= byte_val;
    end else if (cmd.rnd_step) begin
      for (int i = 0; i < sha_pkg::WordCount - 1; i++) w_r[i] <= w_r[i + 1];
      w_r[sha_pkg::WordCount - 1] <= w_new;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.rnd_init) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
    end else if (cmd.rnd_step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // Counters and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init_msg) begin
      fill_r <= '0;
      bits_r <= '0;
      rnd_r  <= '0;
      widx_r <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::InitH[i];
    end else begin
      if (cmd.wr_byte) fill_r <= fill_r + 6'd1;
      if (cmd.count_bits) bits_r <= bits_r + 64'd8;
      if (cmd.rnd_init) rnd_r <= '0;
      else if (cmd.rnd_step) rnd_r <= rnd_r + 6'd1;
      if (cmd.out_step) widx_r <= widx_r + 3'd1;
      if (cmd.chain_add) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
      end
    end
  end

  assign sts.fill      = fill_r;
  assign sts.rnd_last  = (rnd_r == 6'(sha_pkg::RoundCount - 1));
  assign sts.word_last = (widx_r == 3'd7);
  assign digest_word   = chain_r[widx_r];
  assign word_index    = widx_r;

endmodule

// ===== rtl/core/sha_ctrl.sv =====
// Controller: sequences byte intake, padding, compression and digest output.
module sha_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             byte_present,
  input  logic             end_of_message,
  output logic             out_valid,
  input  logic             out_ready,
  output sha_pkg::dp_cmd_t cmd,
  input  sha_pkg::dp_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_RND  = 5'b00100,
    S_ADD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   end_pend_r, end_pend_nxt;
  logic   pad_act_r, pad_act_nxt;
  logic   sent80_r, sent80_nxt;
  logic   lenblk_r, lenblk_nxt;
  logic   acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    end_pend_nxt = end_pend_r;
    pad_act_nxt  = pad_act_r;
    sent80_nxt   = sent80_r;
    lenblk_nxt   = lenblk_r;
    cmd          = '0;
    cmd.byte_sel = sha_pkg::BSEL_DATA;
    case (state_r)
      S_IDLE: begin
        if (acc && byte_present) begin
          cmd.wr_byte    = 1'b1;
          cmd.count_bits = 1'b1;
          if (sts.fill == 6'd63) begin
            cmd.rnd_init = 1'b1;
            end_pend_nxt = end_of_message;
            state_nxt    = S_RND;
          end else if (end_of_message) begin
            pad_act_nxt = 1'b1;
            sent80_nxt  = 1'b0;
            state_nxt   = S_PAD;
          end
        end else if (acc && end_of_message) begin
          pad_act_nxt = 1'b1;
          sent80_nxt  = 1'b0;
          state_nxt   = S_PAD;
        end
      end
      // one padding byte per cycle
      S_PAD: begin
        cmd.wr_byte = 1'b1;
        if (!sent80_r) begin
          cmd.byte_sel = sha_pkg::BSEL_PAD;
          sent80_nxt   = 1'b1;
          lenblk_nxt   = (sts.fill < 6'(sha_pkg::LenStart));
        end else if (lenblk_r && sts.fill >= 6'(sha_pkg::LenStart)) begin
          cmd.byte_sel = sha_pkg::BSEL_LEN;
        end else begin
          cmd.byte_sel = sha_pkg::BSEL_ZERO;
        end
        if (sts.fill == 6'd63) begin
          cmd.rnd_init = 1'b1;
          state_nxt    = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd_step = 1'b1;
        if (sts.rnd_last) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        if (!pad_act_r) begin
          if (end_pend_r) begin
            pad_act_nxt = 1'b1;
            sent80_nxt  = 1'b0;
            state_nxt   = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
          end_pend_nxt = 1'b0;
        end else if (lenblk_r) begin
          state_nxt = S_OUT;
        end else begin
          lenblk_nxt = 1'b1;
          state_nxt  = S_PAD;
        end
      end
      // digest words, one per transaction
      S_OUT: begin
        if (out_ready) begin
          cmd.out_step = 1'b1;
          if (sts.word_last) begin
            cmd.init_msg = 1'b1;
            pad_act_nxt  = 1'b0;
            lenblk_nxt   = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      end_pend_r <= 1'b0;
      pad_act_r  <= 1'b0;
      sent80_r   <= 1'b0;
      lenblk_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      end_pend_r <= end_pend_nxt;
      pad_act_r  <= pad_act_nxt;
      sent80_r   <= sent80_nxt;
      lenblk_r   <= lenblk_nxt;
    end
  end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// A byte item is written into the block buffer; the 64th byte of a block starts compression of that block.
// An end item pads one byte per cycle up to the block end, then compresses,
// once or twice, before the eight digest words appear, one per output transaction.
// Throughput is set by the single shared round unit: one round per cycle, 64 per block.
// Reset (rst_n low, synchronous) loads the initial hash words and clears counts and control.
// Top level: SHA-256 hasher over a byte stream, controller plus datapath.
module sha256_byte_stream_hasher (
  input logic       clk,
  input logic       rst_n,
  sha_in_if.sink    in_chan,
  sha_out_if.source out_chan
);

  sha_pkg::dp_cmd_t cmd;
  sha_pkg::dp_sts_t sts;
  logic             out_valid;

  sha_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .byte_present   (in_chan.byte_present),
    .end_of_message (in_chan.end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_chan.ready),
    .cmd            (cmd),
    .sts            (sts)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .data_byte   (in_chan.data_byte),
    .digest_word (out_chan.digest_word),
    .word_index  (out_chan.word_index)
  );

  assign out_chan.valid     = out_valid;
  assign out_chan.last_word = sts.word_last;

endmodule
